/* sv/awsh_pkg.sv */
// Shared types, constants and shaping helpers for the audio waveshaper.
package awsh_pkg;

  // Shaping curve selected by the mode register
  typedef enum logic [1:0] {
    MODE_SOFT = 2'd0,
    MODE_HARD = 2'd1,
    MODE_FOLD = 2'd2,
    MODE_SINE = 2'd3
  } shape_mode_t;

  // Saturated product x in Q5.18
  localparam int XW = 23;
  localparam logic signed [XW-1:0] XSAT_HI = 23'sd4194303;
  localparam logic signed [XW-1:0] XSAT_LO = -23'sd4194304;
  localparam logic signed [XW-1:0] ONE_Q18 = 23'sd262144;

  // Softclip divider: quotient width, steps and bits per step
  localparam int SC_QW    = 15;
  localparam int SC_BPS   = 3;
  localparam int SC_STEPS = SC_QW / SC_BPS;

  // Sine phase constant and polynomial (Q30)
  localparam logic signed [51:0] PHASE_K = 52'sd170891319;
  localparam int SINE_NCOEF = 5;
  localparam logic signed [31:0] SINE_COEF [SINE_NCOEF] = '{
    32'sd1686629713, -32'sd693598672, 32'sd85569306, -32'sd5026997, 32'sd172272
  };

  // Pipeline stage map (index = stage number minus one)
  localparam int STG_PROD = 0;
  localparam int STG_X    = 1;
  localparam int STG_PREP = 2;
  localparam int STG_Z2   = 3;
  localparam int STG_H0   = 4;
  localparam int STG_FIN  = STG_PREP + SC_STEPS + 1;
  localparam int NUM_STG  = STG_FIN + 2;

  typedef logic [NUM_STG-1:0] stg_en_t;

  // Clamp to [-1,1] and round Q5.18 to Q1.14
  function automatic logic signed [15:0] shape_hard(logic signed [XW-1:0] x);
    logic signed [XW-1:0] hc;
    logic signed [XW:0]   rs;
    hc = x;
    if (x > ONE_Q18) hc = ONE_Q18;
    if (x < -ONE_Q18) hc = -ONE_Q18;
    rs = ((XW+1)'(hc) + 24'sd8) >>> 4;
    return 16'(rs);
  endfunction

  // Fold back into [-1,1] and round Q5.18 to Q1.14
  function automatic logic signed [15:0] shape_fold(logic signed [XW-1:0] x);
    logic signed [XW:0] t;
    logic signed [XW:0] abs_t;
    logic [19:0]        r;
    logic signed [20:0] a;
    logic signed [20:0] abs_a;
    logic signed [21:0] f;
    logic signed [21:0] rs;
    t     = (XW+1)'(x) - (XW+1)'(ONE_Q18);
    abs_t = t[XW] ? -t : t;
    r     = abs_t[19:0];
    a     = $signed({1'b0, r}) - 21'sd524288;
    abs_a = a[20] ? -a : a;
    f     = 22'(abs_a) - 22'sd262144;
    rs    = (f + 22'sd8) >>> 4;
    return 16'(rs);
  endfunction

endpackage

/* sv/audio_waveshaper_core.sv */
// Top level of the audio waveshaper: handshake, stage control, mode register, output mux.
//
// Usage: one request per sample on the in_ channel carries a Q1.14 sample and a
// Q4.11 gain; each produces one Q1.14 shaped sample on the out_ channel. The
// cfg_ port writes the 2-bit shape mode (softclip, hardclip, foldback, sine);
// write it only while no requests are in flight.
// Throughput: one request per cycle while the receiver does not stall. The depth
// is set by the sine path (phase multiply, square, four Horner
// multiplies, final multiply, round) and matched by the softclip divider, which
// retires three quotient bits per stage over five stages.
// Each stage carries a valid bit and moves when the stage after it is empty or
// moving, so bubbles close up. When the receiver stalls, the output register
// holds its request and the stages behind it fill; in_stall rises only once all
// ten stages hold requests. Reset (rst_n low, synchronous) empties every stage
// and sets the mode to softclip.
module audio_waveshaper_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_in,
  input  logic signed [15:0] in_gain_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample_out
);

  localparam int NS  = awsh_pkg::NUM_STG;
  localparam int NHF = awsh_pkg::STG_FIN - awsh_pkg::STG_PREP + 1;

  awsh_pkg::shape_mode_t shape_mode_r;
  awsh_pkg::shape_mode_t mode_r [NS-1];
  awsh_pkg::stg_en_t     en;
  logic [NS-1:0]         vld_r;
  logic signed [awsh_pkg::XW-1:0] x;
  logic signed [15:0]    sc_y;
  logic signed [15:0]    sn_y;
  logic signed [15:0]    hf_nxt;
  logic signed [15:0]    hf_r [NHF];
  logic signed [15:0]    out_sample_r;
  logic signed [15:0]    out_sample_nxt;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= awsh_pkg::MODE_SOFT;
    end else if (cfg_wr_en) begin
      shape_mode_r <= awsh_pkg::shape_mode_t'(cfg_wr_data);
    end
  end

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NS-1] = !vld_r[NS-1] || !out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Mode travels with each request
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mode_r[0] <= shape_mode_r;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        mode_r[k] <= mode_r[k-1];
      end
    end
  end

  awsh_front u_front (
    .clk    (clk),
    .en     (en),
    .sample (in_sample_in),
    .gain   (in_gain_in),
    .x      (x)
  );

  awsh_softclip u_softclip (
    .clk (clk),
    .en  (en),
    .x   (x),
    .y   (sc_y)
  );

  awsh_sine u_sine (
    .clk (clk),
    .en  (en),
    .x   (x),
    .y   (sn_y)
  );

  // Hardclip and foldback settle in one stage, then ride a delay line
  always_comb begin
    if (mode_r[awsh_pkg::STG_X] == awsh_pkg::MODE_FOLD) begin
      hf_nxt = awsh_pkg::shape_fold(x);
    end else begin
      hf_nxt = awsh_pkg::shape_hard(x);
    end
  end

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_PREP]) begin
      hf_r[0] <= hf_nxt;
    end
    for (int j = 1; j < NHF; j++) begin
      if (en[awsh_pkg::STG_PREP+j]) begin
        hf_r[j] <= hf_r[j-1];
      end
    end
  end

  // Select the curve for the output register
  always_comb begin
    case (mode_r[NS-2])
      awsh_pkg::MODE_SOFT: out_sample_nxt = sc_y;
      awsh_pkg::MODE_SINE: out_sample_nxt = sn_y;
      default:             out_sample_nxt = hf_r[NHF-1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid      = vld_r[NS-1];
  assign out_sample_out = out_sample_r;

  // Input is held off only when every stage is full and the receiver stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("in_stall with an empty stage or no output stall");

  // An empty first stage always takes a request
  a_bubble_open: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> !in_stall)
    else $error("empty first stage blocks input");

  // Every result lies within [-1,1]
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_out <= 16'sd16384 && out_sample_out >= -16'sd16384))
    else $error("result outside [-1,1]");

endmodule

/* sv/awsh_front.sv */
// Front end: sample times gain, then rounding and saturation to Q5.18.
module awsh_front (
  input  logic                          clk,
  input  awsh_pkg::stg_en_t             en,
  input  logic signed [15:0]            sample,
  input  logic signed [15:0]            gain,
  output logic signed [awsh_pkg::XW-1:0] x
);

  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;
  logic signed [awsh_pkg::XW-1:0] x_r;
  logic signed [awsh_pkg::XW-1:0] x_nxt;
  logic signed [32:0] rnd;

  // Exact Q5.25 product
  assign prod_nxt = 32'(sample) * 32'(gain);

  // Round to Q5.18, ties up, and saturate
  always_comb begin
    rnd = (33'(prod_r) + 33'sd64) >>> 7;
    if (rnd > 33'(awsh_pkg::XSAT_HI)) begin
      x_nxt = awsh_pkg::XSAT_HI;
    end else if (rnd < 33'(awsh_pkg::XSAT_LO)) begin
      x_nxt = awsh_pkg::XSAT_LO;
    end else begin
      x_nxt = awsh_pkg::XW'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_PROD]) begin
      prod_r <= prod_nxt;
    end
    if (en[awsh_pkg::STG_X]) begin
      x_r <= x_nxt;
    end
  end

  assign x = x_r;

endmodule

/* sv/awsh_softclip.sv */
// Softclip x/(1+|x|): pipelined restoring divider, a few quotient bits per stage.
module awsh_softclip (
  input  logic                           clk,
  input  awsh_pkg::stg_en_t              en,
  input  logic signed [awsh_pkg::XW-1:0] x,
  output logic signed [15:0]             y
);

  typedef struct packed {
    logic [awsh_pkg::XW-1:0]    rem;
    logic [awsh_pkg::SC_QW-1:0] lo;
    logic [awsh_pkg::SC_QW-1:0] q;
    logic [awsh_pkg::XW-1:0]    d;
    logic                       neg;
  } sc_div_t;

  // Retire SC_BPS quotient bits, most significant first
  function automatic sc_div_t div_step(sc_div_t s);
    sc_div_t o;
    logic [awsh_pkg::XW:0] t;
    o = s;
    for (int i = 0; i < awsh_pkg::SC_BPS; i++) begin
      t    = {o.rem, o.lo[awsh_pkg::SC_QW-1]};
      o.lo = {o.lo[awsh_pkg::SC_QW-2:0], 1'b0};
      if (t >= {1'b0, o.d}) begin
        o.rem = awsh_pkg::XW'(t - {1'b0, o.d});
        o.q   = {o.q[awsh_pkg::SC_QW-2:0], 1'b1};
      end else begin
        o.rem = t[awsh_pkg::XW-1:0];
        o.q   = {o.q[awsh_pkg::SC_QW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  localparam int NW = awsh_pkg::XW + 14;

  sc_div_t st_r [awsh_pkg::SC_STEPS+1];
  sc_div_t prep_nxt;
  logic [awsh_pkg::XW-1:0] mag;
  logic [awsh_pkg::XW-1:0] den;
  logic [NW-1:0]           num;
  logic signed [15:0]      y_r;
  logic signed [15:0]      y_nxt;

  // Set up numerator |x|*2^14 + d/2 over d = 1 + |x|
  always_comb begin
    mag = x[awsh_pkg::XW-1] ? awsh_pkg::XW'(-x) : awsh_pkg::XW'(x);
    den = mag + awsh_pkg::XW'(awsh_pkg::ONE_Q18);
    num = {mag, 14'b0} + NW'(den[awsh_pkg::XW-1:1]);
    prep_nxt.rem = awsh_pkg::XW'(num[NW-1:awsh_pkg::SC_QW]);
    prep_nxt.lo  = num[awsh_pkg::SC_QW-1:0];
    prep_nxt.q   = '0;
    prep_nxt.d   = den;
    prep_nxt.neg = x[awsh_pkg::XW-1];
  end

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_PREP]) begin
      st_r[0] <= prep_nxt;
    end
  end

  // Divider stages
  for (genvar j = 1; j <= awsh_pkg::SC_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[awsh_pkg::STG_PREP+j]) begin
        st_r[j] <= div_step(st_r[j-1]);
      end
    end
  end

  // Apply the sign of x
  always_comb begin
    if (st_r[awsh_pkg::SC_STEPS].neg) begin
      y_nxt = -16'({1'b0, st_r[awsh_pkg::SC_STEPS].q});
    end else begin
      y_nxt = 16'({1'b0, st_r[awsh_pkg::SC_STEPS].q});
    end
  end

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_FIN]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

/* sv/awsh_sine.sv */
// Sine of x: phase multiply, quadrant fold, Horner polynomial one multiply per stage.
module awsh_sine (
  input  logic                           clk,
  input  awsh_pkg::stg_en_t              en,
  input  logic signed [awsh_pkg::XW-1:0] x,
  output logic signed [15:0]             y
);

  localparam int NH = awsh_pkg::SINE_NCOEF - 1;

  logic [31:0]        ph_r;
  logic signed [51:0] ph_full;
  logic [30:0]        zm;
  logic [61:0]        zz;
  logic [30:0]        z_r   [NH+1];
  logic [30:0]        z2_r  [NH];
  logic [1:0]         quad_r[NH+1];
  logic signed [31:0] acc_r [NH];
  logic signed [63:0] ps;
  logic signed [33:0] s_r;
  logic [1:0]         quad_s_r;
  logic signed [33:0] rs;
  logic [14:0]        mag;

  // Phase in turns, 32-bit wrapping fraction
  assign ph_full = 52'(x) * awsh_pkg::PHASE_K;

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_PREP]) begin
      ph_r <= ph_full[47:16];
    end
  end

  // Mirror odd quadrants, square z
  always_comb begin
    if (ph_r[30]) begin
      zm = 31'h4000_0000 - {1'b0, ph_r[29:0]};
    end else begin
      zm = {1'b0, ph_r[29:0]};
    end
    zz = 62'(zm) * 62'(zm);
  end

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_Z2]) begin
      z_r[0]    <= zm;
      z2_r[0]   <= zz[60:30];
      quad_r[0] <= ph_r[31:30];
    end
  end

  // Horner steps, highest coefficient first
  for (genvar h = 0; h < NH; h++) begin : g_horner
    logic signed [31:0] acc_in;
    logic signed [63:0] pr;
    if (h == 0) begin : g_first
      assign acc_in = awsh_pkg::SINE_COEF[NH];
    end else begin : g_next
      assign acc_in = acc_r[h-1];
    end
    assign pr = $signed(64'(acc_in)) * $signed(64'(z2_r[h]));
    always_ff @(posedge clk) begin
      if (en[awsh_pkg::STG_H0+h]) begin
        acc_r[h]    <= awsh_pkg::SINE_COEF[NH-1-h] + 32'(pr >>> 30);
        z_r[h+1]    <= z_r[h];
        quad_r[h+1] <= quad_r[h];
      end
    end
    if (h < NH - 1) begin : g_z2
      always_ff @(posedge clk) begin
        if (en[awsh_pkg::STG_H0+h]) begin
          z2_r[h+1] <= z2_r[h];
        end
      end
    end
  end

  // Final multiply by z
  assign ps = $signed(64'(acc_r[NH-1])) * $signed(64'(z_r[NH]));

  always_ff @(posedge clk) begin
    if (en[awsh_pkg::STG_FIN]) begin
      s_r      <= 34'(ps >>> 30);
      quad_s_r <= quad_r[NH];
    end
  end

  // Round to Q1.14, clamp to [0,1], negate in the lower half turn
  always_comb begin
    rs = (s_r + 34'sd32768) >>> 16;
    if (rs < 34'sd0) begin
      mag = '0;
    end else if (rs > 34'sd16384) begin
      mag = 15'd16384;
    end else begin
      mag = rs[14:0];
    end
    if (quad_s_r[1]) begin
      y = -16'(mag);
    end else begin
      y = 16'(mag);
    end
  end

endmodule
